FILE: hw/rtl/vtso_pkg.sv
// Shared widths, constants and types for the vCPU time-stamp offset sync block.
package vtso_pkg;

   localparam int DATA_W      = 64;
   localparam int THR_W       = 32;
   localparam int CPU_FIELD_W = 6;
   localparam int REQ_DATA_W  = 200;
   localparam int RSP_DATA_W  = 72;

   localparam logic [THR_W-1:0] THR_RESET = 32'd30000;

   // divide by three, one nibble per step: q = (v * RECIP3) >> RECIP3_SHIFT for v < 48
   localparam int DIGIT_W      = 4;
   localparam int DIV_STEPS    = DATA_W / DIGIT_W;
   localparam int RECIP3       = 43;
   localparam int RECIP3_SHIFT = 7;

   typedef logic [DATA_W-1:0] word_type;

   typedef struct packed {
      logic     bad_cpu;
      logic     raw_count_backwards;
      logic     guest_time_backwards;
      logic     adjust_valid;
      word_type offset_adjust;
   } result_type;

endpackage

FILE: hw/rtl/vtso_div3.sv
// Iterative unsigned divide-by-three, one nibble of quotient per cycle.
module vtso_div3 (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  vtso_pkg::word_type dividend,
   output logic               done,
   output vtso_pkg::word_type quotient
);

   localparam int STEP_W = $clog2(vtso_pkg::DIV_STEPS);
   localparam int V_W    = vtso_pkg::DIGIT_W + 2;
   localparam int P_W    = V_W + 7;

   vtso_pkg::word_type dvd_ff, dvd_in;
   vtso_pkg::word_type quo_ff, quo_in;
   logic [1:0]         rem_ff, rem_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   logic [V_W-1:0]                 v;
   logic [P_W-1:0]                 prod;
   logic [vtso_pkg::DIGIT_W-1:0]   q;
   logic [V_W-1:0]                 r;

   always_comb begin
      v    = {rem_ff, dvd_ff[vtso_pkg::DATA_W-1 -: vtso_pkg::DIGIT_W]};
      prod = P_W'(v) * P_W'(vtso_pkg::RECIP3);
      q    = prod[vtso_pkg::RECIP3_SHIFT +: vtso_pkg::DIGIT_W];
      r    = v - V_W'(3 * q);

      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         quo_in  = '0;
         rem_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in  = dvd_ff << vtso_pkg::DIGIT_W;
         quo_in  = {quo_ff[vtso_pkg::DATA_W-vtso_pkg::DIGIT_W-1:0], q};
         rem_in  = r[1:0];
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(vtso_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: hw/rtl/vcpu_tsc_offset_sync.sv
// Top level of the vCPU time-stamp offset sync block: exit table and entry offset sequencer.
//
//   channel  direction  handshake           payload
//   req      in         req_tvalid/tready   tuser kind, tdata cpu/count/offset/host
//   rsp      out        rsp_tvalid/tready   tdata offset_adjust and flags
//   csr      in         csr_valid/ready     csr_data skew_threshold
//
// One item at a time: an exit passes through S_EXRD and S_EXCMP; a bad CPU number or a zero-count
// entry goes straight to S_DONE. An entry makes one table read per slot through the single read
// port, a 16-step divide by three, the final sum. Reset empties the table at once through
// per-slot valid bits and sets skew_threshold to 30000. A stalled rsp holds its item in the
// output register while the next req is taken.
module vcpu_tsc_offset_sync #(
   parameter int NUM_CPUS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [0] kind
   input  logic                               req_tuser,
   // [5:0] cpu_index, [69:6] count_at_exit, [133:70] offset_at_exit, [197:134] host_count
   input  logic [vtso_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [63:0] offset_adjust, [64] adjust_valid, [65] guest_time_backwards,
   // [66] raw_count_backwards, [67] bad_cpu
   output logic [vtso_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [vtso_pkg::THR_W-1:0]         csr_data
);

   localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int SCAN_W = $clog2(NUM_CPUS + 1);
   localparam int DW     = vtso_pkg::DATA_W;
   localparam int FW     = vtso_pkg::CPU_FIELD_W;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_EXRD   = 4'd1;
   localparam logic [3:0] S_EXCMP  = 4'd2;
   localparam logic [3:0] S_ENPAST = 4'd3;
   localparam logic [3:0] S_SCAN   = 4'd4;
   localparam logic [3:0] S_GAP    = 4'd5;
   localparam logic [3:0] S_THR    = 4'd6;
   localparam logic [3:0] S_DIV    = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   // request fields
   logic                 in_kind;
   logic [FW-1:0]        in_cpu;
   vtso_pkg::word_type   in_cnt, in_off, in_host;
   logic                 req_fire;

   assign in_kind  = req_tuser;
   assign in_cpu   = req_tdata[FW-1:0];
   assign in_cnt   = req_tdata[FW +: DW];
   assign in_off   = req_tdata[FW+DW +: DW];
   assign in_host  = req_tdata[FW+2*DW +: DW];
   assign req_fire = req_tvalid && req_tready;

   // table memory: {count, offset} per slot
   logic [2*DW-1:0]      mem [NUM_CPUS];
   logic [2*DW-1:0]      rd_data_ff;
   logic                 rd_vld_ff;
   logic [NUM_CPUS-1:0]  vld_ff, vld_in;
   logic [CPU_W-1:0]     rd_addr;
   logic                 wr_en;
   vtso_pkg::word_type   rd_cnt, rd_off;

   logic [3:0]           state_ff, state_in;
   logic [vtso_pkg::THR_W-1:0] thr_ff, thr_in;
   logic [CPU_W-1:0]     cpu_ff, cpu_in;
   vtso_pkg::word_type   cnt_ff, cnt_in, off_ff, off_in, host_ff, host_in;
   vtso_pkg::word_type   lastg_ff, lastg_in, newg_ff, newg_in;
   logic                 rawb_ff, rawb_in;
   vtso_pkg::word_type   past_ff, past_in, hoff_ff, hoff_in, base_ff, base_in;
   vtso_pkg::word_type   best_ff, best_in, g_ff, g_in, gap_ff, gap_in;
   logic                 gv_ff, gv_in, p1_ff, p1_in, gt_ff, gt_in;
   logic [SCAN_W-1:0]    scan_ff, scan_in;
   vtso_pkg::result_type res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [vtso_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                 issuing, slot_free, big;
   logic                 div_start, div_done;
   vtso_pkg::word_type   div_dvd, div_quo;

   assign rd_cnt    = rd_vld_ff ? rd_data_ff[2*DW-1:DW] : '0;
   assign rd_off    = rd_vld_ff ? rd_data_ff[DW-1:0] : '0;
   assign issuing   = (state_ff == S_SCAN) && (scan_ff < SCAN_W'(NUM_CPUS));
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign big       = gt_ff && (gap_ff > DW'(thr_ff));

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      if (state_ff == S_IDLE) begin
         rd_addr = in_cpu[CPU_W-1:0];
      end else begin
         rd_addr = scan_ff[CPU_W-1:0];
      end
   end

   assign wr_en = (state_ff == S_EXRD);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cpu_ff] <= {cnt_ff, off_ff};
      end
      rd_data_ff <= mem[rd_addr];
   end

   vtso_div3 u_div3 (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      thr_in       = thr_ff;
      vld_in       = vld_ff;
      cpu_in       = cpu_ff;
      cnt_in       = cnt_ff;
      off_in       = off_ff;
      host_in      = host_ff;
      lastg_in     = lastg_ff;
      newg_in      = newg_ff;
      rawb_in      = rawb_ff;
      past_in      = past_ff;
      hoff_in      = hoff_ff;
      base_in      = base_ff;
      best_in      = best_ff;
      gap_in       = gap_ff;
      gt_in        = gt_ff;
      scan_in      = scan_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      div_dvd      = big ? gap_ff : '0;
      p1_in        = issuing;
      g_in         = rd_cnt + rd_off;
      gv_in        = p1_ff && (rd_cnt != '0);

      if (csr_valid) begin
         thr_in = csr_data;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cpu_in  = in_cpu[CPU_W-1:0];
               cnt_in  = in_cnt;
               off_in  = in_off;
               host_in = in_host;
               res_in  = '0;
               if (!in_kind) begin
                  if ({1'b0, in_cpu} >= (FW+1)'(NUM_CPUS)) begin
                     res_in.bad_cpu = 1'b1;
                     state_in       = S_DONE;
                  end else begin
                     state_in = S_EXRD;
                  end
               end else if (in_cnt == '0) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_ENPAST;
               end
            end
         end
         S_EXRD: begin
            lastg_in       = rd_cnt + rd_off;
            newg_in        = cnt_ff + off_ff;
            rawb_in        = (cnt_ff != '0) && (cnt_ff < rd_cnt);
            vld_in[cpu_ff] = 1'b1;
            state_in       = S_EXCMP;
         end
         S_EXCMP: begin
            res_in.guest_time_backwards = (cnt_ff != '0) && (lastg_ff > newg_ff);
            res_in.raw_count_backwards  = rawb_ff;
            state_in                    = S_DONE;
         end
         S_ENPAST: begin
            past_in  = cnt_ff + off_ff;
            hoff_in  = host_ff + off_ff;
            best_in  = '0;
            scan_in  = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            base_in = past_ff - hoff_ff;
            if (issuing) begin
               scan_in = scan_ff + SCAN_W'(1);
            end
            if (gv_ff && (g_ff > best_ff)) begin
               best_in = g_ff;
            end
            if (!issuing && !p1_ff && !gv_ff) begin
               state_in = S_GAP;
            end
         end
         S_GAP: begin
            gap_in   = best_ff - past_ff;
            gt_in    = best_ff > past_ff;
            state_in = S_THR;
         end
         S_THR: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               res_in.offset_adjust = div_quo + base_ff;
               res_in.adjust_valid  = 1'b1;
               state_in             = S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = vtso_pkg::RSP_DATA_W'(res_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rd_vld_ff   <= vld_ff[rd_addr];
      cpu_ff      <= cpu_in;
      cnt_ff      <= cnt_in;
      off_ff      <= off_in;
      host_ff     <= host_in;
      lastg_ff    <= lastg_in;
      newg_ff     <= newg_in;
      rawb_ff     <= rawb_in;
      past_ff     <= past_in;
      hoff_ff     <= hoff_in;
      base_ff     <= base_in;
      best_ff     <= best_in;
      g_ff        <= g_in;
      gap_ff      <= gap_in;
      gt_ff       <= gt_in;
      scan_ff     <= scan_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         thr_ff       <= vtso_pkg::THR_RESET;
         vld_ff       <= '0;
         p1_ff        <= 1'b0;
         gv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         vld_ff       <= vld_in;
         p1_ff        <= p1_in;
         gv_ff        <= gv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: bench/vcpu_tsc_offset_sync_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for vcpu_tsc_offset_sync: directed table, then random exit and entry items.
module vcpu_tsc_offset_sync_tb;

   localparam int       N_CPU         = 32;
   localparam int       SLOT_W        = $clog2(N_CPU);
   localparam logic     KIND_EXIT     = 1'b0;
   localparam logic     KIND_ENTRY    = 1'b1;
   localparam int       MAX_GAP       = 17;
   localparam int       STALL_LIMIT   = 4000;
   localparam int       DRAIN_CYCLES  = 80;
   localparam int       PHASE_ITEMS   = 200;
   localparam int       N_PHASES      = 6;
   localparam int       RANDOM_PHASE  = 3;
   localparam int       DIR_N         = 21;
   localparam vtso_pkg::word_type ALL_ONES = '1;

   localparam logic [3:0] F_NONE       = 4'b0000;
   localparam logic [3:0] F_VALID      = 4'b0001;
   localparam logic [3:0] F_GUEST_BACK = 4'b0010;
   localparam logic [3:0] F_RAW_BACK   = 4'b0100;
   localparam logic [3:0] F_BAD_CPU    = 4'b1000;

   typedef struct packed {
      logic                             kind;
      logic [vtso_pkg::CPU_FIELD_W-1:0] cpu;
      vtso_pkg::word_type               count;
      vtso_pkg::word_type               offset;
      vtso_pkg::word_type               host;
   } sync_req_type;

   typedef struct packed {
      sync_req_type       req;
      logic               fixed;
      logic [3:0]         flags;
      vtso_pkg::word_type adjust;
   } dir_row_type;

   localparam dir_row_type DIR_ROWS [DIR_N] = '{
      '{'{KIND_ENTRY, 6'd0,  64'd0,    64'd0,    64'd0},    1'b1, F_NONE,    64'd0},
      '{'{KIND_ENTRY, 6'd0,  64'd1000, 64'd0,    64'd100},  1'b1, F_VALID,   64'd900},
      '{'{KIND_EXIT,  6'd63, ALL_ONES, ALL_ONES, 64'd0},    1'b1, F_BAD_CPU, 64'd0},
      '{'{KIND_EXIT,  6'd32, 64'd5,    64'd0,    64'd0},    1'b1, F_BAD_CPU, 64'd0},
      '{'{KIND_EXIT,  6'd0,  64'd100000, 64'd0,  64'd0},    1'b1, F_NONE,    64'd0},
      '{'{KIND_ENTRY, 6'd0,  64'd70000, 64'd0,   64'd70000}, 1'b0, F_NONE,   64'd0},
      '{'{KIND_ENTRY, 6'd0,  64'd69999, 64'd0,   64'd0},    1'b0, F_NONE,    64'd0},
      '{'{KIND_EXIT,  6'd0,  64'd500,  64'd100,  64'd0},    1'b1, F_GUEST_BACK | F_RAW_BACK,
        64'd0},
      '{'{KIND_EXIT,  6'd0,  64'd600,  64'd0,    64'd0},    1'b1, F_NONE,    64'd0},
      '{'{KIND_EXIT,  6'd0,  64'd0,    64'd5,    64'd0},    1'b1, F_NONE,    64'd0},
      '{'{KIND_EXIT,  6'd0,  64'd1,    64'd0,    64'd0},    1'b1, F_GUEST_BACK, 64'd0},
      '{'{KIND_EXIT,  6'd1,  64'd42,   ALL_ONES, 64'd0},    1'b0, F_NONE,    64'd0},
      '{'{KIND_EXIT,  6'd31, ALL_ONES, ALL_ONES, 64'd0},    1'b0, F_NONE,    64'd0},
      '{'{KIND_ENTRY, 6'd63, 64'd1,    ALL_ONES, ALL_ONES}, 1'b0, F_NONE,    64'd0},
      '{'{KIND_ENTRY, 6'd0,  ALL_ONES, 64'd0,    64'd0},    1'b0, F_NONE,    64'd0},
      '{'{KIND_EXIT,  6'd31, 64'd0,    64'd0,    64'd0},    1'b1, F_NONE,    64'd0},
      '{'{KIND_EXIT,  6'd1,  64'd0,    64'd0,    64'd0},    1'b1, F_NONE,    64'd0},
      '{'{KIND_EXIT,  6'd0,  64'd0,    64'd0,    64'd0},    1'b1, F_NONE,    64'd0},
      '{'{KIND_ENTRY, 6'd0,  64'd5,    64'd7,    64'd2},    1'b1, F_VALID,   64'd3},
      '{'{KIND_EXIT,  6'd16, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0},
        1'b0, F_NONE, 64'd0},
      '{'{KIND_ENTRY, 6'd0,  64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
        64'h1234}, 1'b0, F_NONE, 64'd0}
   };

   localparam logic [vtso_pkg::THR_W-1:0] PHASE_THR [N_PHASES] = '{
      32'd0, 32'hFFFF_FFFF, 32'd1000, 32'd0, 32'd30000, 32'd1
   };

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic                            req_tuser  = 1'b0;
   logic [vtso_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [vtso_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            csr_valid  = 1'b0;
   logic                            csr_ready;
   logic [vtso_pkg::THR_W-1:0]      csr_data   = '0;

   logic                  req_fixed   = 1'b0;
   vtso_pkg::result_type  req_want    = '0;
   logic                  req_idle_on = 1'b1;
   logic                  rsp_idle_on = 1'b1;

   vtso_pkg::word_type          slot_count  [N_CPU];
   vtso_pkg::word_type          slot_offset [N_CPU];
   logic [vtso_pkg::THR_W-1:0]  skew_thr;
   vtso_pkg::result_type        sync_results_due [$];
   int                          results_due     = 0;
   int                          mismatch_count  = 0;
   int unsigned                 rsp_hold        = 0;
   int unsigned                 rsp_wait;
   int                          idle_cycles     = 0;
   sync_req_type                seen_req;

   vtso_pkg::word_type          tsc_now   = '0;
   vtso_pkg::word_type          guest_off = '0;
   vtso_pkg::word_type          skew_ref  = 64'd30000;

   vcpu_tsc_offset_sync #(
      .NUM_CPUS (N_CPU)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   function automatic vtso_pkg::result_type tsc_sync_result(input sync_req_type r);
      vtso_pkg::result_type res;
      vtso_pkg::word_type   prev_time;
      vtso_pkg::word_type   new_time;
      vtso_pkg::word_type   entry_time;
      vtso_pkg::word_type   best;
      vtso_pkg::word_type   slot_time;
      vtso_pkg::word_type   lag;
      vtso_pkg::word_type   adj;
      logic [SLOT_W-1:0]    slot;
      res = '0;
      if (r.kind == KIND_EXIT) begin
         if (r.cpu >= N_CPU) begin
            res.bad_cpu = 1'b1;
         end else begin
            slot      = r.cpu[SLOT_W-1:0];
            prev_time = slot_count[slot] + slot_offset[slot];
            new_time  = r.count + r.offset;
            if (r.count != '0) begin
               res.guest_time_backwards = prev_time > new_time;
               res.raw_count_backwards  = r.count < slot_count[slot];
            end
            slot_count[slot]  = r.count;
            slot_offset[slot] = r.offset;
         end
      end else if (r.count != '0) begin
         entry_time = r.count + r.offset;
         best = '0;
         for (int i = 0; i < N_CPU; i++) begin
            if (slot_count[i] != '0) begin
               slot_time = slot_count[i] + slot_offset[i];
               if (slot_time > best) best = slot_time;
            end
         end
         adj = '0;
         lag = best - entry_time;
         if (best > entry_time && lag > vtso_pkg::word_type'(skew_thr)) adj = lag / 64'd3;
         res.offset_adjust = adj - r.offset + (entry_time - r.host);
         res.adjust_valid  = 1'b1;
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input vtso_pkg::word_type got,
                                  input vtso_pkg::word_type want);
      $display("%0t: %s: got %h, expected %h", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_result(input vtso_pkg::result_type seen);
      vtso_pkg::result_type want;
      if (sync_results_due.size() == 0) begin
         report_mismatch("result with none pending", seen.offset_adjust, '0);
      end else begin
         want = sync_results_due.pop_front();
         if (seen.offset_adjust !== want.offset_adjust)
            report_mismatch("offset_adjust", seen.offset_adjust, want.offset_adjust);
         if (seen.adjust_valid !== want.adjust_valid)
            report_mismatch("adjust_valid", vtso_pkg::word_type'(seen.adjust_valid),
                            vtso_pkg::word_type'(want.adjust_valid));
         if (seen.guest_time_backwards !== want.guest_time_backwards)
            report_mismatch("guest_time_backwards",
                            vtso_pkg::word_type'(seen.guest_time_backwards),
                            vtso_pkg::word_type'(want.guest_time_backwards));
         if (seen.raw_count_backwards !== want.raw_count_backwards)
            report_mismatch("raw_count_backwards",
                            vtso_pkg::word_type'(seen.raw_count_backwards),
                            vtso_pkg::word_type'(want.raw_count_backwards));
         if (seen.bad_cpu !== want.bad_cpu)
            report_mismatch("bad_cpu", vtso_pkg::word_type'(seen.bad_cpu),
                            vtso_pkg::word_type'(want.bad_cpu));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready  <= 1'b0;
         rsp_hold    <= 0;
         results_due <= 0;
         skew_thr    = vtso_pkg::THR_RESET;
         for (int i = 0; i < N_CPU; i++) begin
            slot_count[i]  = '0;
            slot_offset[i] = '0;
         end
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_result(vtso_pkg::result_type'(rsp_tdata[$bits(vtso_pkg::result_type)-1:0]));
            rsp_wait = rsp_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (rsp_wait != 0) begin
               rsp_tready <= 1'b0;
               rsp_hold   <= rsp_wait;
            end
         end else if (!rsp_tready) begin
            if (rsp_hold > 1) rsp_hold <= rsp_hold - 1;
            else rsp_tready <= 1'b1;
         end
         if (csr_valid && csr_ready) skew_thr = csr_data;
         if (req_tvalid && req_tready) begin
            seen_req.kind   = req_tuser;
            seen_req.cpu    = req_tdata[5:0];
            seen_req.count  = req_tdata[69:6];
            seen_req.offset = req_tdata[133:70];
            seen_req.host   = req_tdata[197:134];
            if (req_fixed) begin
               void'(tsc_sync_result(seen_req));
               sync_results_due.push_back(req_want);
            end else begin
               sync_results_due.push_back(tsc_sync_result(seen_req));
            end
         end
         results_due <= sync_results_due.size();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("vcpu_tsc_offset_sync test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_req(input sync_req_type r, input logic fixed,
                           input vtso_pkg::result_type want);
      int unsigned gap;
      gap = req_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.kind;
      req_tdata  <= vtso_pkg::REQ_DATA_W'({r.host, r.offset, r.count, r.cpu});
      req_fixed  <= fixed;
      req_want   <= want;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [vtso_pkg::THR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      skew_ref  = vtso_pkg::word_type'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // exits track a running host count; entries lag it by a small, near-threshold or large skew
   function automatic sync_req_type make_req(input logic noisy);
      sync_req_type       r;
      vtso_pkg::word_type skew;
      int unsigned        pick;
      pick     = $urandom_range(0, 99);
      r.kind   = ($urandom_range(0, 3) == 0) ? KIND_ENTRY : KIND_EXIT;
      r.cpu    = 6'($urandom_range(0, N_CPU - 1));
      r.offset = guest_off;
      if (r.kind == KIND_EXIT) begin
         tsc_now = tsc_now + vtso_pkg::word_type'($urandom_range(1, 3000));
         r.count = tsc_now + vtso_pkg::word_type'($urandom_range(0, 3));
      end else begin
         case ($urandom_range(0, 3))
            0:       skew = vtso_pkg::word_type'($urandom_range(0, 200));
            1:       skew = skew_ref - 64'd1 + vtso_pkg::word_type'($urandom_range(0, 3));
            2:       skew = 64'd3 * skew_ref + vtso_pkg::word_type'($urandom_range(0, 5000));
            default: skew = {24'd0, $urandom, 8'($urandom)};
         endcase
         r.count = tsc_now - skew;
      end
      r.host = tsc_now + vtso_pkg::word_type'($urandom_range(0, 500));
      if (pick < 8) begin
         r.cpu = 6'($urandom_range(N_CPU, 63));
      end else if (pick < 14) begin
         r.count = '0;
      end else if (pick < 20) begin
         r.count = r.count - vtso_pkg::word_type'($urandom_range(1, 5000));
      end else if (pick < 25) begin
         r.offset = guest_off - vtso_pkg::word_type'($urandom_range(1, 5000));
      end else if (noisy && pick < 35) begin
         r.cpu    = 6'($urandom);
         r.count  = {$urandom, $urandom};
         r.offset = {$urandom, $urandom};
         r.host   = {$urandom, $urandom};
      end
      return r;
   endfunction

   initial begin
      sync_req_type               sweep;
      logic                       noisy;
      logic [vtso_pkg::THR_W-1:0] thr_value;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int k = 0; k < DIR_N; k++)
         send_req(DIR_ROWS[k].req, DIR_ROWS[k].fixed,
                  vtso_pkg::result_type'({DIR_ROWS[k].flags, DIR_ROWS[k].adjust}));
      for (int p = 0; p < N_PHASES; p++) begin
         drain_results();
         thr_value = (p == RANDOM_PHASE) ? $urandom_range(2000, 200000) : PHASE_THR[p];
         write_threshold(thr_value);
         noisy       = p[0];
         req_idle_on = (p % 3) != 1;
         rsp_idle_on <= (p % 3) == 0;
         tsc_now     = {$urandom, $urandom};
         guest_off   = {$urandom, $urandom};
         if (!noisy) begin
            // empty every slot so the scan sees only this phase's exits
            for (int k = 0; k < N_CPU; k++) begin
               sweep        = '0;
               sweep.kind   = KIND_EXIT;
               sweep.cpu    = 6'(k);
               sweep.offset = {$urandom, $urandom};
               send_req(sweep, 1'b0, '0);
            end
         end
         for (int k = 0; k < PHASE_ITEMS; k++)
            send_req(make_req(noisy), 1'b0, '0);
      end
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sync_results_due.size() != 0)
         report_mismatch("results never arrived",
                         vtso_pkg::word_type'(sync_results_due.size()), '0);
      if (mismatch_count == 0)
         $display("vcpu_tsc_offset_sync test passed");
      else
         $display("vcpu_tsc_offset_sync test failed");
      $finish;
   end

endmodule
